### rtl/core/text_console_writer_assert.svh
// Assertion macros shared by the text console writer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define TCW_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text console writer: assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text console writer: assertion failed");

`endif

### rtl/core/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Depends on nothing; used by the front, queue, back and top level.
`default_nettype none

package tcw_pkg;

   // Fixed field widths of the request and response words.
   localparam int FUNC_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int ADDR_IN_W  = 11;
   localparam int ROW_OUT_W  = 5;
   localparam int COL_OUT_W  = 7;
   localparam int CELL_W     = 16;
   localparam int ATTR_W     = 8;

   // Widest internal fields over the supported screen sizes.
   localparam int ADDR_W_MAX = 15;
   localparam int ROW_W_MAX  = 7;
   localparam int COL_W_MAX  = 8;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

   // Kind of work the back end carries out for one word.
   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_PUT   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_kind_type;

   // One classified command, with the cursor it reports.
   typedef struct packed {
      cmd_kind_type              kind;
      logic                      wr_en;
      logic [ADDR_W_MAX-1:0]     wr_addr;
      logic [CELL_W-1:0]         wr_data;
      logic                      scroll;
      logic [ADDR_W_MAX-1:0]     rd_addr;
      logic                      rd_in_range;
      logic [ATTR_W-1:0]         attr;
      logic [ROW_W_MAX-1:0]      row;
      logic [COL_W_MAX-1:0]      col;
   } cmd_type;

   // Status of the back end toward the top level.
   typedef struct packed {
      logic walking;
      logic reading;
   } back_status_type;

endpackage

`default_nettype wire

### rtl/core/text_console_writer.sv
// Top level of the text console writer: attribute register, front, queue, back.
// Depends on tcw_pkg, tcw_front, tcw_cmd_queue, tcw_back and the assert macros.
//
// Usage:
//   A request word (req_func, req_char_code, req_cell_address) is taken at a
//   rising edge with start high and busy low. Each word gives exactly one
//   response word on rsp_cursor_row, rsp_cursor_col and rsp_cell_data, shown
//   for one cycle with rsp_valid high; the receiver cannot hold it off.
//   The attribute byte is written with csr_write_enable and csr_write_data;
//   the user must write it only while the block is idle, which the block
//   itself does not enforce; it resets to 0x07. A put, newline or backspace
//   that does not scroll and an unused code sustain one word per cycle; a read
//   waits on the screen memory's registered read port before the back end
//   takes the next word. A clear and a put that scrolls hold the back end
//   while it walks the memory one cell per cycle through its single write
//   port. A two-entry command queue lets the front keep taking words while
//   the back works; busy is high while that queue is full.
//   Reset homes the cursor, empties the queue and idles the back end; screen
//   cells hold nothing defined until written.
`default_nettype none

`include "text_console_writer_assert.svh"

module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [tcw_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input  wire logic [tcw_pkg::ADDR_IN_W-1:0]   req_cell_address,
   output logic                                 rsp_valid,
   output logic [tcw_pkg::ROW_OUT_W-1:0]        rsp_cursor_row,
   output logic [tcw_pkg::COL_OUT_W-1:0]        rsp_cursor_col,
   output logic [tcw_pkg::CELL_W-1:0]           rsp_cell_data,
   input  wire logic                            csr_write_enable,
   input  wire logic [tcw_pkg::ATTR_W-1:0]      csr_write_data
);

   logic [tcw_pkg::ATTR_W-1:0]  attribute_ff;
   logic                        accept;
   tcw_pkg::cmd_type            front_cmd;
   tcw_pkg::cmd_type            head_cmd;
   logic                        q_empty;
   logic                        q_full;
   logic                        pop;
   tcw_pkg::back_status_type    back_status;
   logic [2:0]                  outstanding_ff, outstanding_in;

   assign accept = start && !busy;
   assign busy   = q_full;

   // Attribute register.
   always_ff @(posedge clock) begin
      if (reset) begin
         attribute_ff <= tcw_pkg::ATTR_RESET;
      end else if (csr_write_enable) begin
         attribute_ff <= csr_write_data;
      end
   end

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_func         (req_func),
      .req_char_code    (req_char_code),
      .req_cell_address (req_cell_address),
      .attribute        (attribute_ff),
      .cmd              (front_cmd)
   );

   tcw_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .status         (back_status),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cell_data  (rsp_cell_data)
   );

   // Words taken but not yet answered.
   assign outstanding_in = outstanding_ff + 3'(accept) - 3'(rsp_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // A response always answers a word that was taken earlier.
   `TCW_ASSERT_IMPLIES(a_rsp_has_word, clock, reset, rsp_valid, outstanding_ff != 3'd0)
   // The reported cursor stays on the screen.
   `TCW_ASSERT_IMPLIES(a_cursor_on_screen, clock, reset, rsp_valid,
      (32'(rsp_cursor_row) < ROWS) && (32'(rsp_cursor_col) < COLUMNS))
   // No response goes out while the memory walk is under way.
   `TCW_ASSERT_IMPLIES(a_walk_silent, clock, reset, back_status.walking, !rsp_valid)
   // A memory walk never ends in the cycle it starts.
   `TCW_ASSERT_NEXT(a_walk_spans, clock, reset, $rose(back_status.walking), back_status.walking)
   // A cell read holds the reading status high for a single cycle only.
   `TCW_ASSERT_NEXT(a_read_one_cycle, clock, reset, back_status.reading,
      !back_status.reading)

endmodule

`default_nettype wire

### rtl/core/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/tcw_cmd_queue.sv
// Short command queue between the front and the back of the console writer.
// Depends on tcw_pkg for the command type and the queue depth.
`default_nettype none

module tcw_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire tcw_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output tcw_pkg::cmd_type      head_cmd,
   output logic                  empty,
   output logic                  full
);

   localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW  = $clog2(DEPTH + 1);

   tcw_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CNTW-1:0]  count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + PW'(1);
      end
      if (pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Stored commands.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_cmd;
      end
   end

   assign head_cmd = entry_ff[head_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNTW'(DEPTH));

endmodule

`default_nettype wire

### rtl/core/tcw_front.sv
// Front end of the console writer: keeps the cursor and turns each request
// word into one command for the back end. Depends on tcw_pkg.
`default_nettype none

module tcw_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            accept,
   input  wire logic [tcw_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [tcw_pkg::CHAR_W-1:0]      req_char_code,
   input  wire logic [tcw_pkg::ADDR_IN_W-1:0]   req_cell_address,
   input  wire logic [tcw_pkg::ATTR_W-1:0]      attribute,
   output tcw_pkg::cmd_type                     cmd
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int AMW   = tcw_pkg::ADDR_W_MAX;
   localparam int RMW   = tcw_pkg::ROW_W_MAX;
   localparam int CMW   = tcw_pkg::COL_W_MAX;
   localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] pos;

   // Linear cell index of the cursor.
   assign pos = AW'(row_ff) * COLS_A + AW'(col_ff);

   // Classify the request word and work out the cursor after it.
   always_comb begin
      row_in          = row_ff;
      col_in          = col_ff;
      cmd             = '0;
      cmd.kind        = tcw_pkg::CMD_NONE;
      cmd.attr        = attribute;
      case (req_func)
         tcw_pkg::FUNC_PUT: begin
            cmd.kind = tcw_pkg::CMD_PUT;
            if (req_char_code == tcw_pkg::CH_NEWLINE) begin
               col_in = '0;
               if (row_ff == LAST_ROW) begin
                  cmd.scroll = 1'b1;
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end else if (req_char_code == tcw_pkg::CH_BACKSPACE) begin
               // Backspace at the line start leaves everything alone.
               if (col_ff != '0) begin
                  col_in      = col_ff - CW'(1);
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = AMW'(pos - AW'(1));
                  cmd.wr_data = {attribute, tcw_pkg::CH_BLANK};
               end
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = AMW'(pos);
               cmd.wr_data = {attribute, req_char_code};
               if (col_ff == LAST_COL) begin
                  col_in = '0;
                  if (row_ff == LAST_ROW) begin
                     cmd.scroll = 1'b1;
                  end else begin
                     row_in = row_ff + RW'(1);
                  end
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
         end
         tcw_pkg::FUNC_CLEAR: begin
            cmd.kind = tcw_pkg::CMD_CLEAR;
            row_in   = '0;
            col_in   = '0;
         end
         tcw_pkg::FUNC_READ: begin
            cmd.kind        = tcw_pkg::CMD_READ;
            cmd.rd_addr     = AMW'(req_cell_address);
            cmd.rd_in_range = (32'(req_cell_address) < CELLS);
         end
         default: begin
            cmd.kind = tcw_pkg::CMD_NONE;
         end
      endcase
      cmd.row = RMW'(row_in);
      cmd.col = CMW'(col_in);
   end

   // Cursor registers follow every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/tcw_back.sv
// Back end of the console writer: carries out queued commands on the
// screen memory and drives the response word. Depends on tcw_pkg, tcw_ram.
`default_nettype none

module tcw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             q_empty,
   input  wire tcw_pkg::cmd_type                 head_cmd,
   output logic                                  pop,
   output tcw_pkg::back_status_type              status,
   output logic                                  rsp_valid,
   output logic [tcw_pkg::ROW_OUT_W-1:0]         rsp_cursor_row,
   output logic [tcw_pkg::COL_OUT_W-1:0]         rsp_cursor_col,
   output logic [tcw_pkg::CELL_W-1:0]            rsp_cell_data
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int ROW_OW = tcw_pkg::ROW_OUT_W;
   localparam int COL_OW = tcw_pkg::COL_OUT_W;
   localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
   localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
   localparam logic [AW-1:0] COPY_LAST  = AW'(CELLS - COLUMNS - 1);
   localparam logic [AW-1:0] FILL_FIRST = AW'(CELLS - COLUMNS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_SCROLL = 4'b0100,
      ST_FILL   = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   logic [AW-1:0]                cnt_ff, cnt_in;
   logic                         wb_valid_ff, wb_valid_in;
   logic [AW-1:0]                wb_addr_ff, wb_addr_in;
   tcw_pkg::cmd_type             hold_ff, hold_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ROW_OW-1:0]            rsp_row_ff, rsp_row_in;
   logic [COL_OW-1:0]            rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::CELL_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [tcw_pkg::CELL_W-1:0]   ram_wdata;
   logic                         ram_re;
   logic [AW-1:0]                ram_raddr;
   logic [tcw_pkg::CELL_W-1:0]   ram_rdata;

   logic                         emit;
   tcw_pkg::cmd_type             emit_src;
   logic [tcw_pkg::CELL_W-1:0]   emit_data;
   logic [tcw_pkg::CELL_W-1:0]   blank;

   assign blank = {hold_ff.attr, tcw_pkg::CH_BLANK};

   // Screen memory.
   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Command sequencer: single words, reads, scroll copy and blank fill.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      wb_valid_in = wb_valid_ff;
      wb_addr_in  = wb_addr_ff;
      hold_in     = hold_ff;
      pop         = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = wb_addr_ff;
      ram_wdata   = ram_rdata;
      ram_re      = 1'b0;
      ram_raddr   = cnt_ff + COLS_A;
      emit        = 1'b0;
      emit_src    = hold_ff;
      emit_data   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               hold_in = head_cmd;
               case (head_cmd.kind)
                  tcw_pkg::CMD_PUT: begin
                     ram_we    = head_cmd.wr_en;
                     ram_waddr = AW'(head_cmd.wr_addr);
                     ram_wdata = head_cmd.wr_data;
                     if (head_cmd.scroll) begin
                        state_in    = ST_SCROLL;
                        cnt_in      = '0;
                        wb_valid_in = 1'b0;
                     end else begin
                        emit     = 1'b1;
                        emit_src = head_cmd;
                     end
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     state_in    = ST_FILL;
                     cnt_in      = '0;
                     wb_valid_in = 1'b0;
                  end
                  tcw_pkg::CMD_READ: begin
                     ram_re    = 1'b1;
                     ram_raddr = AW'(head_cmd.rd_addr);
                     state_in  = ST_READ;
                  end
                  default: begin
                     emit     = 1'b1;
                     emit_src = head_cmd;
                  end
               endcase
            end
         end
         ST_READ: begin
            emit      = 1'b1;
            emit_data = hold_ff.rd_in_range ? ram_rdata : '0;
            state_in  = ST_IDLE;
         end
         ST_SCROLL: begin
            // Read one line below, write back the cell read the cycle before.
            ram_we      = wb_valid_ff;
            ram_re      = 1'b1;
            wb_addr_in  = cnt_ff;
            wb_valid_in = 1'b1;
            if (cnt_ff == COPY_LAST) begin
               state_in = ST_FILL;
               cnt_in   = FILL_FIRST;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_FILL: begin
            // A pending copy from the scroll goes first, then blanks.
            ram_we = 1'b1;
            if (wb_valid_ff) begin
               wb_valid_in = 1'b0;
            end else begin
               ram_waddr = cnt_ff;
               ram_wdata = blank;
               if (cnt_ff == LAST_CELL) begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = emit;
      rsp_row_in   = emit ? ROW_OW'(emit_src.row) : rsp_row_ff;
      rsp_col_in   = emit ? COL_OW'(emit_src.col) : rsp_col_ff;
      rsp_data_in  = emit ? emit_data : rsp_data_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      wb_addr_ff  <= wb_addr_in;
      hold_ff     <= hold_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.walking = (state_ff == ST_SCROLL) || (state_ff == ST_FILL);
   assign status.reading = (state_ff == ST_READ);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_data  = rsp_data_ff;

endmodule

`default_nettype wire
